// ===== design/assert_macros.svh =====
// assertion macros for the classifier top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define HBG_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("hbg assertion failed");

// condition holds in the cycle after the trigger
`define HBG_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("hbg assertion failed");

`endif

// ===== design/hbg_pkg.sv =====
// types and constants for the pixel hue/gray classifier
package hbg_pkg;

  localparam int unsigned HsvShift = 12;
  localparam int unsigned SatNum   = 255 << HsvShift;
  localparam int unsigned HueNum   = 180 << HsvShift;

  localparam int unsigned SatTabW  = 20;  // max entry 1044480
  localparam int unsigned HueTabW  = 17;  // max entry 122880
  localparam int unsigned HnumW    = 12;  // hue numerator, signed
  localparam int unsigned SprodW   = 28;
  localparam int unsigned HprodW   = 30;

  localparam logic [7:0] HueWrap   = 8'd180;

  // class kinds
  localparam logic [2:0] KIND_CHROMA = 3'd0;
  localparam logic [2:0] KIND_WHITE  = 3'd1;
  localparam logic [2:0] KIND_GRAY   = 3'd2;
  localparam logic [2:0] KIND_BLACK  = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_SAT_MIN    = 3'd0;
  localparam logic [2:0] REG_VAL_MIN    = 3'd1;
  localparam logic [2:0] REG_WHITE_LVL  = 3'd2;
  localparam logic [2:0] REG_BLACK_LVL  = 3'd3;
  localparam logic [2:0] REG_CODE_WHITE = 3'd4;
  localparam logic [2:0] REG_CODE_GRAY  = 3'd5;
  localparam logic [2:0] REG_CODE_BLACK = 3'd6;

  typedef struct packed {
    logic [7:0] sat_min;
    logic [7:0] val_min_chroma;
    logic [7:0] white_level;
    logic [7:0] black_level;
    logic [7:0] code_white;
    logic [7:0] code_gray;
    logic [7:0] code_black;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0]               val;
    logic [7:0]               diff;
    logic signed [HnumW-1:0]  hnum;
    logic [SatTabW-1:0]       sat_recip;
    logic [HueTabW-1:0]       hue_recip;
  } prep_t;

  typedef struct packed {
    logic [7:0]               val;
    logic [SprodW-1:0]        sprod;
    logic signed [HprodW-1:0] hprod;
  } prod_t;

endpackage

// ===== design/hbg_prep.sv =====
// max/min/spread, hue numerator and reciprocal table lookups
module hbg_prep (
  input  hbg_pkg::pix_t  pix,
  output hbg_pkg::prep_t prep
);

  logic [hbg_pkg::SatTabW-1:0] sat_tab [256];
  logic [hbg_pkg::HueTabW-1:0] hue_tab [256];

  // reciprocal tables, rounded to nearest with ties to even
  for (genvar gi = 0; gi < 256; gi++) begin : g_tab
    localparam int unsigned SDiv = (gi == 0) ? 1 : gi;
    localparam int unsigned SQ   = hbg_pkg::SatNum / SDiv;
    localparam int unsigned SR   = hbg_pkg::SatNum % SDiv;
    localparam int unsigned SUp  = ((2 * SR > SDiv) || (2 * SR == SDiv && SQ % 2 == 1)) ? 1 : 0;
    localparam int unsigned SVal = (gi == 0) ? 0 : SQ + SUp;
    localparam int unsigned HDiv = (gi == 0) ? 6 : 6 * gi;
    localparam int unsigned HQ   = hbg_pkg::HueNum / HDiv;
    localparam int unsigned HR   = hbg_pkg::HueNum % HDiv;
    localparam int unsigned HUp  = ((2 * HR > HDiv) || (2 * HR == HDiv && HQ % 2 == 1)) ? 1 : 0;
    localparam int unsigned HVal = (gi == 0) ? 0 : HQ + HUp;
    assign sat_tab[gi] = hbg_pkg::SatTabW'(SVal);
    assign hue_tab[gi] = hbg_pkg::HueTabW'(HVal);
  end

  logic [7:0] vmax;
  logic [7:0] vmin;
  logic [7:0] diff;
  logic signed [hbg_pkg::HnumW-1:0] b_s, g_s, r_s, d_s;

  always_comb begin
    vmax = pix.blue;
    if (pix.green > vmax) vmax = pix.green;
    if (pix.red > vmax) vmax = pix.red;
    vmin = pix.blue;
    if (pix.green < vmin) vmin = pix.green;
    if (pix.red < vmin) vmin = pix.red;
    diff = vmax - vmin;
    b_s = hbg_pkg::HnumW'({1'b0, pix.blue});
    g_s = hbg_pkg::HnumW'({1'b0, pix.green});
    r_s = hbg_pkg::HnumW'({1'b0, pix.red});
    d_s = hbg_pkg::HnumW'({1'b0, diff});
  end

  always_comb begin
    prep.val       = vmax;
    prep.diff      = diff;
    prep.sat_recip = sat_tab[vmax];
    prep.hue_recip = hue_tab[diff];
    priority if (vmax == pix.red) begin
      prep.hnum = g_s - b_s;
    end else if (vmax == pix.green) begin
      prep.hnum = b_s - r_s + (d_s <<< 1);
    end else begin
      prep.hnum = r_s - g_s + (d_s <<< 2);
    end
  end

endmodule

// ===== design/hbg_scale.sv =====
// fixed-point products for saturation and hue
module hbg_scale (
  input  hbg_pkg::prep_t prep,
  output hbg_pkg::prod_t prod
);

  logic signed [hbg_pkg::HueTabW:0] recip_s;

  always_comb begin
    recip_s    = $signed({1'b0, prep.hue_recip});
    prod.val   = prep.val;
    prod.sprod = hbg_pkg::SprodW'(prep.diff * prep.sat_recip);
    prod.hprod = hbg_pkg::HprodW'(prep.hnum * recip_s);
  end

endmodule

// ===== design/hbg_classify.sv =====
// rounding of saturation and hue, then the color/white/gray/black decision
module hbg_classify (
  input  hbg_pkg::prod_t prod,
  input  hbg_pkg::cfg_t  cfg,
  output logic [7:0]     class_code,
  output logic [2:0]     class_kind
);

  localparam int unsigned Half = 1 << (hbg_pkg::HsvShift - 1);

  logic [hbg_pkg::SprodW:0]         s_sum;
  logic [8:0]                       sat;
  logic signed [hbg_pkg::HprodW:0]  h_sum;
  logic signed [hbg_pkg::HprodW:0]  h_shr;
  logic signed [8:0]                hue_s;
  logic [7:0]                       hue;
  logic [7:0]                       v;

  always_comb begin
    v     = prod.val;
    s_sum = {1'b0, prod.sprod} + (hbg_pkg::SprodW + 1)'(Half);
    sat   = 9'(s_sum >> hbg_pkg::HsvShift);
    // floor division of a signed value is an arithmetic shift
    h_sum = {prod.hprod[hbg_pkg::HprodW-1], prod.hprod} + (hbg_pkg::HprodW + 1)'(Half);
    h_shr = h_sum >>> hbg_pkg::HsvShift;
    hue_s = h_shr[8:0];
    hue   = hue_s[8] ? (hue_s[7:0] + hbg_pkg::HueWrap) : hue_s[7:0];

    priority if (sat > {1'b0, cfg.sat_min} && v > cfg.val_min_chroma) begin
      class_code = hue;
      class_kind = hbg_pkg::KIND_CHROMA;
    end else if (v > cfg.white_level) begin
      class_code = cfg.code_white;
      class_kind = hbg_pkg::KIND_WHITE;
    end else if (v > cfg.black_level && v < cfg.white_level) begin
      class_code = cfg.code_gray;
      class_kind = hbg_pkg::KIND_GRAY;
    end else if (v < cfg.black_level) begin
      class_code = cfg.code_black;
      class_kind = hbg_pkg::KIND_BLACK;
    end else begin
      class_code = 8'd0;
      class_kind = hbg_pkg::KIND_NONE;
    end
  end

endmodule

// ===== design/bgr_pixel_hue_gray_class_core.sv =====
// top level: bgr pixel to hsv, then hue/white/gray/black classification
// an input beat passes through the input register, then the result register, to the output
// throughput one pixel per cycle while out_tready is high, set by the single pass of combinational logic
//   (lookup, multiply, classify) between the input register and the result register
// back pressure holds the result register, and the input register once it is full
// reset (rst_n low, synchronous) empties both registers and loads default thresholds
`include "assert_macros.svh"

module bgr_pixel_hue_gray_class_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // class_code[7:0]
  output logic [2:0]  out_tuser,  // class_kind[2:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  hbg_pkg::cfg_t  cfg_r;
  hbg_pkg::pix_t  pix_r;
  hbg_pkg::prep_t prep;
  hbg_pkg::prod_t prod;
  logic [7:0]     code_nxt;
  logic [2:0]     kind_nxt;
  logic [7:0]     code_r;
  logic [2:0]     kind_r;

  logic v_in_r, v_out_r;
  logic ld_out, ld_in;

  // a register may load when it is empty or its contents move on
  assign ld_out    = !v_out_r || out_tready;
  assign ld_in     = !v_in_r || ld_out;
  assign in_tready = ld_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sat_min        <= 8'd60;
      cfg_r.val_min_chroma <= 8'd20;
      cfg_r.white_level    <= 8'd200;
      cfg_r.black_level    <= 8'd50;
      cfg_r.code_white     <= 8'd180;
      cfg_r.code_gray      <= 8'd181;
      cfg_r.code_black     <= 8'd182;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbg_pkg::REG_SAT_MIN:    cfg_r.sat_min        <= cfg_data;
        hbg_pkg::REG_VAL_MIN:    cfg_r.val_min_chroma <= cfg_data;
        hbg_pkg::REG_WHITE_LVL:  cfg_r.white_level    <= cfg_data;
        hbg_pkg::REG_BLACK_LVL:  cfg_r.black_level    <= cfg_data;
        hbg_pkg::REG_CODE_WHITE: cfg_r.code_white     <= cfg_data;
        hbg_pkg::REG_CODE_GRAY:  cfg_r.code_gray      <= cfg_data;
        hbg_pkg::REG_CODE_BLACK: cfg_r.code_black     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r  <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (ld_in) v_in_r <= in_tvalid;
      if (ld_out) v_out_r <= v_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in && in_tvalid) pix_r <= hbg_pkg::pix_t'({in_tdata[7:0], in_tdata[15:8],
                                                      in_tdata[23:16]});
    if (ld_out && v_in_r) begin
      code_r <= code_nxt;
      kind_r <= kind_nxt;
    end
  end

  hbg_prep u_prep (
    .pix  (pix_r),
    .prep (prep)
  );

  hbg_scale u_scale (
    .prep (prep),
    .prod (prod)
  );

  hbg_classify u_classify (
    .prod       (prod),
    .cfg        (cfg_r),
    .class_code (code_nxt),
    .class_kind (kind_nxt)
  );

  assign out_tvalid = v_out_r;
  assign out_tdata  = code_r;
  assign out_tuser  = kind_r;

  // a chromatic beat always carries a wrapped hue
  `HBG_ASSERT_SAME(a_hue_range, clk, rst_n,
    out_tvalid && out_tuser == hbg_pkg::KIND_CHROMA, out_tdata < hbg_pkg::HueWrap)
  // kind is never past the unclassified code
  `HBG_ASSERT_SAME(a_kind_range, clk, rst_n, out_tvalid, out_tuser <= hbg_pkg::KIND_NONE)
  // an accepted beat lands in the input register
  `HBG_ASSERT_NEXT(a_in_load, clk, rst_n, in_tvalid && in_tready, v_in_r)
  // a held pixel reaches the result register when it is free
  `HBG_ASSERT_NEXT(a_out_load, clk, rst_n, v_in_r && ld_out, out_tvalid)

endmodule

// ===== dv/bgr_pixel_hue_gray_class_checker.sv =====
// checker for the pixel classifier: predicts each output beat and compares it
module bgr_pixel_hue_gray_class_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // class_code[7:0]
  input  logic [2:0]  out_tuser,  // class_kind[2:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [7:0] code;
    logic [2:0] kind;
  } class_beat_t;

  localparam hbg_pkg::cfg_t CfgDefault = '{sat_min: 8'd60, val_min_chroma: 8'd20,
                                           white_level: 8'd200, black_level: 8'd50,
                                           code_white: 8'd180, code_gray: 8'd181,
                                           code_black: 8'd182};

  hbg_pkg::cfg_t thresholds = CfgDefault;
  class_beat_t   expected_classes[$];
  int            beat_count = 0;
  int            fail_count = 0;
  int            queued     = 0;

  assign mismatches = fail_count;
  assign pending    = queued;

  // reciprocal table entry: num / den rounded to nearest, ties to even
  function automatic int recip_even(int unsigned num, int unsigned den);
    int unsigned q;
    int unsigned r;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q = q + 1;
    return int'(q);
  endfunction

  // drop the 12 fraction bits, rounding half up (floor for negatives)
  function automatic int fix_round(int x);
    return (x + (1 << (hbg_pkg::HsvShift - 1))) >>> hbg_pkg::HsvShift;
  endfunction

  function automatic class_beat_t predict_class(logic [23:0] pixel, hbg_pkg::cfg_t c);
    int blu, grn, rd;
    int vmax, vmin, spread, sat, hue;
    class_beat_t res;
    blu = int'(pixel[7:0]);
    grn = int'(pixel[15:8]);
    rd  = int'(pixel[23:16]);
    vmax = blu;
    vmin = blu;
    if (grn > vmax) vmax = grn;
    if (rd > vmax) vmax = rd;
    if (grn < vmin) vmin = grn;
    if (rd < vmin) vmin = rd;
    spread = vmax - vmin;

    sat = (vmax == 0) ? 0 : fix_round(spread * recip_even(hbg_pkg::SatNum, vmax));

    if (vmax == rd) hue = grn - blu;
    else if (vmax == grn) hue = blu - rd + 2 * spread;
    else hue = rd - grn + 4 * spread;
    hue = (spread == 0) ? 0 : fix_round(hue * recip_even(hbg_pkg::HueNum, 6 * spread));
    if (hue < 0) hue = hue + 180;

    if (sat > int'(c.sat_min) && vmax > int'(c.val_min_chroma)) begin
      res.code = 8'(hue);
      res.kind = hbg_pkg::KIND_CHROMA;
    end else if (vmax > int'(c.white_level)) begin
      res.code = c.code_white;
      res.kind = hbg_pkg::KIND_WHITE;
    end else if (vmax > int'(c.black_level) && vmax < int'(c.white_level)) begin
      res.code = c.code_gray;
      res.kind = hbg_pkg::KIND_GRAY;
    end else if (vmax < int'(c.black_level)) begin
      res.code = c.code_black;
      res.kind = hbg_pkg::KIND_BLACK;
    end else begin
      res.code = 8'd0;
      res.kind = hbg_pkg::KIND_NONE;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at output beat %0d: %s", beat_count, what);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    class_beat_t exp_beat;
    if (!rst_n) begin
      thresholds = CfgDefault;
      expected_classes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hbg_pkg::REG_SAT_MIN:    thresholds.sat_min        = cfg_data;
          hbg_pkg::REG_VAL_MIN:    thresholds.val_min_chroma = cfg_data;
          hbg_pkg::REG_WHITE_LVL:  thresholds.white_level    = cfg_data;
          hbg_pkg::REG_BLACK_LVL:  thresholds.black_level    = cfg_data;
          hbg_pkg::REG_CODE_WHITE: thresholds.code_white     = cfg_data;
          hbg_pkg::REG_CODE_GRAY:  thresholds.code_gray      = cfg_data;
          hbg_pkg::REG_CODE_BLACK: thresholds.code_black     = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_classes = {expected_classes, predict_class(in_tdata, thresholds)};
      if (out_tvalid && out_tready) begin
        if (expected_classes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat code %0d kind %0d",
                                    out_tdata, out_tuser));
        end else begin
          exp_beat = expected_classes.pop_front();
          if (out_tdata !== exp_beat.code)
            report_mismatch($sformatf("class_code %0d, expected %0d",
                                      out_tdata, exp_beat.code));
          if (out_tuser !== exp_beat.kind)
            report_mismatch($sformatf("class_kind %0d, expected %0d",
                                      out_tuser, exp_beat.kind));
        end
        beat_count = beat_count + 1;
      end
    end
    queued = expected_classes.size();
  end

endmodule

// ===== dv/bgr_pixel_hue_gray_class_core_test.sv =====
// testbench top for the pixel classifier: clock, reset, stimulus and verdict
module bgr_pixel_hue_gray_class_core_test;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 140;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = 24'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = hbg_pkg::REG_SAT_MIN;
  logic [7:0]  cfg_data   = 8'd0;

  int   mismatches;
  int   pending;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off      = 1'b0;
  event hold_off_start;
  hbg_pkg::cfg_t cur_cfg = '{sat_min: 8'd60, val_min_chroma: 8'd20, white_level: 8'd200,
                             black_level: 8'd50, code_white: 8'd180, code_gray: 8'd181,
                             code_black: 8'd182};

  bgr_pixel_hue_gray_class_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bgr_pixel_hue_gray_class_checker class_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always begin
    @(hold_off_start);
    hold_off <= 1'b1;
    repeat (64) @(negedge clk);
    hold_off <= 1'b0;
  end

  // called and returns at a falling edge; leaves tvalid high for the next beat
  task automatic send_pixel(input hbg_pkg::pix_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.red, p.green, p.blue};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_cfg(input hbg_pkg::cfg_t c);
    logic [2:0] reg_order[7];
    logic [7:0] reg_vals[7];
    reg_order = '{hbg_pkg::REG_SAT_MIN, hbg_pkg::REG_VAL_MIN, hbg_pkg::REG_WHITE_LVL,
                  hbg_pkg::REG_BLACK_LVL, hbg_pkg::REG_CODE_WHITE, hbg_pkg::REG_CODE_GRAY,
                  hbg_pkg::REG_CODE_BLACK};
    reg_vals  = '{c.sat_min, c.val_min_chroma, c.white_level, c.black_level,
                  c.code_white, c.code_gray, c.code_black};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= reg_vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic hbg_pkg::pix_t random_pixel();
    hbg_pkg::pix_t p;
    logic [7:0]    lvl;
    int            pick;
    pick    = $urandom_range(0, 99);
    p.blue  = 8'($urandom);
    p.green = 8'($urandom);
    p.red   = 8'($urandom);
    if (pick < 15) begin
      p.green = p.blue;
      p.red   = p.blue;
    end else if (pick < 27) begin
      // gray right on or next to a level
      lvl = $urandom_range(0, 1) ? cur_cfg.white_level : cur_cfg.black_level;
      lvl = lvl + 8'($urandom_range(0, 2)) - 8'd1;
      p = {lvl, lvl, lvl};
    end else if (pick < 45) begin
      // low spread, saturation near the threshold region
      p.green = p.blue + 8'($urandom_range(0, 8)) - 8'd4;
      p.red   = p.blue + 8'($urandom_range(0, 8)) - 8'd4;
    end else if (pick < 60) begin
      case ($urandom_range(0, 2))
        0: p.green = p.red;
        1: p.blue  = p.red;
        default: p.blue = p.green;
      endcase
    end
    return p;
  endfunction

  function automatic hbg_pkg::cfg_t random_cfg();
    hbg_pkg::cfg_t c;
    c = hbg_pkg::cfg_t'(56'({$urandom, $urandom}));
    return c;
  endfunction

  initial begin
    hbg_pkg::pix_t corner_pixels[$];
    hbg_pkg::cfg_t next_cfg;
    corner_pixels = '{
      {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
      {8'd200, 8'd200, 8'd200}, {8'd50,  8'd50,  8'd50},  {8'd30,  8'd30,  8'd30},
      {8'd201, 8'd201, 8'd201}, {8'd0,   8'd0,   8'd255}, {8'd0,   8'd255, 8'd0},
      {8'd255, 8'd0,   8'd0},   {8'd255, 8'd0,   8'd255}, {8'd100, 8'd0,   8'd255},
      {8'd0,   8'd255, 8'd255}, {8'd255, 8'd255, 8'd0},   {8'd100, 8'd110, 8'd120},
      {8'd21,  8'd0,   8'd0},   {8'd20,  8'd0,   8'd0},   {8'd170, 8'd85,  8'd170},
      {8'd85,  8'd170, 8'd85},  {8'd1,   8'd0,   8'd0},   {8'd254, 8'd1,   8'd127}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 45;
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 28;
        recv_idle_pct = 45;
      end else if (seg < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      next_cfg = random_cfg();
      case (seg)
        0: next_cfg = '0;
        1: next_cfg = '1;
        2: begin
          // black level above white level
          next_cfg.white_level = 8'($urandom_range(10, 100));
          next_cfg.black_level = 8'($urandom_range(120, 250));
          next_cfg.sat_min = 8'($urandom_range(0, 120));
        end
        4: begin
          next_cfg.sat_min        = 8'd60;
          next_cfg.val_min_chroma = 8'd20;
          next_cfg.white_level    = 8'd200;
          next_cfg.black_level    = 8'd50;
        end
        default: next_cfg.sat_min = 8'($urandom_range(0, 160));
      endcase
      program_cfg(next_cfg);
      if (seg == 0 || seg == 4) -> hold_off_start;
      repeat (RandomItems) send_pixel(random_pixel());
      drain();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
